/* hw/rtl/ddc_edid_fetch_i2c_master_core_assert.svh */
// assertion macros for the ddc edid fetch core
`ifndef DDC_EDID_FETCH_I2C_MASTER_CORE_ASSERT_SVH
`define DDC_EDID_FETCH_I2C_MASTER_CORE_ASSERT_SVH

`ifndef SYNTHESIS
// property checked on every clock edge outside reset
`define DDC_ASSERT(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
		else $error("ddc core assertion failed");
// antecedent in one cycle implies consequent in the next
`define DDC_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("ddc core assertion failed");
`else
`define DDC_ASSERT(lbl, prop)
`define DDC_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

/* hw/rtl/ddc_pkg.sv */
// shared types, constants and helpers for the ddc edid fetch core
`timescale 1ns / 1ps

package ddc_pkg;

	localparam logic [7:0] MAX_BYTES = 8'd128;

	// configuration register indexes
	localparam logic [1:0] REG_HALF_PERIOD = 2'd0;
	localparam logic [1:0] REG_DEV_ADDR    = 2'd1;
	localparam logic [1:0] REG_BYTE_COUNT  = 2'd2;

	// fetch status codes
	localparam logic [2:0] ST_OK          = 3'd0;
	localparam logic [2:0] ST_BUS_BUSY    = 3'd1;
	localparam logic [2:0] ST_ADDR_NAK    = 3'd2;
	localparam logic [2:0] ST_OFFSET_NAK  = 3'd3;
	localparam logic [2:0] ST_BAD_HEADER  = 3'd4;

	localparam logic [15:0] RST_HALF_PERIOD = 16'd250;
	localparam logic [6:0]  RST_DEV_ADDR    = 7'd80;
	localparam logic [7:0]  RST_BYTE_COUNT  = 8'd128;

	typedef struct packed {
		logic [15:0] half_period_ticks;
		logic [6:0]  device_address;
		logic [7:0]  byte_count;
	} cfg_t;

	typedef struct packed {
		logic       scl_release;
		logic       sda_release;
		logic       byte_valid;
		logic [7:0] byte_value;
		logic [6:0] byte_index;
		logic       fetch_done;
		logic [2:0] fetch_status;
		logic       busy_res;
	} res_t;

	function automatic logic [7:0] read_count(input logic [7:0] count);
		return (count > MAX_BYTES) ? MAX_BYTES : count;
	endfunction

	// edid header is 00 ff ff ff ff ff ff 00
	function automatic logic [7:0] header_byte(input logic [2:0] pos);
		return (pos == 3'd0 || pos == 3'd7) ? 8'h00 : 8'hff;
	endfunction

endpackage

/* hw/rtl/ddc_engine.sv */
// bus timing state machine: one tick of i2c master work per advance
`timescale 1ns / 1ps

module ddc_engine (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          advance,
	input  logic          go,
	input  logic          scl_sense,
	input  logic          sda_sense,
	input  ddc_pkg::cfg_t cfg,
	output ddc_pkg::res_t res_next
);

	typedef enum logic [4:0] {
		PH_IDLE, PH_WR_LOW, PH_WR_HIGH, PH_WR_ACK_LOW, PH_WR_ACK_HIGH, PH_WR_ACK_WAIT,
		PH_RS_A, PH_RS_B, PH_RS_C, PH_RS_CHECK, PH_RD_LOW, PH_RD_HIGH, PH_RD_SAMPLE,
		PH_RD_ACK_LOW, PH_RD_ACK_HIGH, PH_RD_ACK_WAIT, PH_STOP_A, PH_STOP_B, PH_STOP_C
	} phase_t;

	typedef enum logic [1:0] {
		STG_ADDR_W, STG_OFFSET, STG_ADDR_R
	} stage_t;

	typedef struct packed {
		phase_t      phase;
		logic [3:0]  bit_cnt;
		logic [7:0]  shift;
		logic [7:0]  bytes_read;
		logic [15:0] delay;
		logic        header_good;
		logic        scl_out;
		logic        sda_out;
		stage_t      stage;
		logic [2:0]  pend_status;
	} st_t;

	typedef struct packed {
		st_t        st;
		logic       valid;
		logic [7:0] value;
		logic [6:0] index;
		logic       done;
		logic [2:0] status;
		logic       chain;
	} eng_t;

	st_t st_q;

	function automatic eng_t act(input eng_t e, input logic go_i, input logic scl_i,
		input logic sda_i, input ddc_pkg::cfg_t c);
		eng_t        n;
		logic [15:0] reload;
		logic [7:0]  rc;
		n = e;
		n.chain = 1'b0;
		reload = (c.half_period_ticks == 16'd0) ? 16'd0 : c.half_period_ticks - 16'd1;
		rc = ddc_pkg::read_count(c.byte_count);
		unique case (e.st.phase)
			PH_IDLE: begin
				if (go_i) begin
					if (!scl_i || !sda_i) begin
						n.done = 1'b1;
						n.status = ddc_pkg::ST_BUS_BUSY;
						n.st.delay = 16'd0;
					end else begin
						n.st.header_good = 1'b1;
						n.st.pend_status = ddc_pkg::ST_OK;
						n.st.bytes_read = 8'd0;
						n.st.stage = STG_ADDR_W;
						n.st.bit_cnt = 4'd0;
						n.st.shift = {c.device_address, 1'b0};
						n.st.sda_out = 1'b0;
						n.st.phase = PH_WR_LOW;
						n.st.delay = reload;
					end
				end
			end
			PH_WR_LOW: begin
				n.st.scl_out = 1'b0;
				n.st.sda_out = e.st.shift[7];
				n.st.phase = PH_WR_HIGH;
				n.st.delay = reload;
			end
			PH_WR_HIGH: begin
				n.st.scl_out = 1'b1;
				n.st.shift = {e.st.shift[6:0], 1'b0};
				n.st.bit_cnt = e.st.bit_cnt + 4'd1;
				n.st.phase = n.st.bit_cnt[3] ? PH_WR_ACK_LOW : PH_WR_LOW;
				n.st.delay = reload;
			end
			PH_WR_ACK_LOW: begin
				n.st.scl_out = 1'b0;
				n.st.sda_out = 1'b1;
				n.st.phase = PH_WR_ACK_HIGH;
				n.st.delay = reload;
			end
			PH_WR_ACK_HIGH: begin
				n.st.scl_out = 1'b1;
				n.st.phase = PH_WR_ACK_WAIT;
				n.st.delay = reload;
			end
			PH_WR_ACK_WAIT: begin
				n.st.delay = reload;
				// slave holding scl low: keep waiting
				if (scl_i) begin
					n.st.bit_cnt = 4'd0;
					if (sda_i) begin
						n.st.pend_status = (e.st.stage == STG_OFFSET) ?
							ddc_pkg::ST_OFFSET_NAK : ddc_pkg::ST_ADDR_NAK;
						n.st.phase = PH_STOP_A;
					end else if (e.st.stage == STG_ADDR_W) begin
						n.st.stage = STG_OFFSET;
						n.st.shift = 8'h00;
						n.st.phase = PH_WR_LOW;
					end else if (e.st.stage == STG_OFFSET) begin
						n.st.phase = PH_RS_A;
					end else begin
						n.st.phase = (rc == 8'd0) ? PH_STOP_A : PH_RD_LOW;
					end
				end
			end
			PH_RS_A: begin
				n.st.scl_out = 1'b0;
				n.st.phase = PH_RS_B;
				n.st.delay = reload;
			end
			PH_RS_B: begin
				n.st.sda_out = 1'b1;
				n.st.phase = PH_RS_C;
				n.st.delay = reload;
			end
			PH_RS_C: begin
				n.st.scl_out = 1'b1;
				n.st.phase = PH_RS_CHECK;
				n.st.delay = reload;
			end
			PH_RS_CHECK: begin
				if (!scl_i || !sda_i) begin
					n.done = 1'b1;
					n.status = ddc_pkg::ST_BUS_BUSY;
					n.st.phase = PH_IDLE;
					n.st.delay = 16'd0;
				end else begin
					n.st.stage = STG_ADDR_R;
					n.st.bit_cnt = 4'd0;
					n.st.shift = {c.device_address, 1'b1};
					n.st.sda_out = 1'b0;
					n.st.phase = PH_WR_LOW;
					n.st.delay = reload;
				end
			end
			PH_RD_LOW: begin
				n.st.scl_out = 1'b0;
				n.st.sda_out = 1'b1;
				n.st.phase = PH_RD_HIGH;
				n.st.delay = reload;
			end
			PH_RD_HIGH: begin
				n.st.scl_out = 1'b1;
				n.st.phase = PH_RD_SAMPLE;
				n.st.delay = reload;
			end
			PH_RD_SAMPLE: begin
				n.st.shift = {e.st.shift[6:0], sda_i};
				n.st.bit_cnt = e.st.bit_cnt + 4'd1;
				n.st.phase = n.st.bit_cnt[3] ? PH_RD_ACK_LOW : PH_RD_LOW;
				n.chain = 1'b1;
			end
			PH_RD_ACK_LOW: begin
				n.st.scl_out = 1'b0;
				// ack all but the last byte
				n.st.sda_out = (({1'b0, e.st.bytes_read} + 9'd1) < {1'b0, rc}) ? 1'b0 : 1'b1;
				n.st.phase = PH_RD_ACK_HIGH;
				n.st.delay = reload;
			end
			PH_RD_ACK_HIGH: begin
				n.st.scl_out = 1'b1;
				n.st.phase = PH_RD_ACK_WAIT;
				n.st.delay = reload;
			end
			PH_RD_ACK_WAIT: begin
				if (!scl_i) begin
					n.st.delay = reload;
				end else begin
					n.valid = 1'b1;
					n.value = e.st.shift;
					n.index = e.st.bytes_read[6:0];
					if (e.st.bytes_read < 8'd8 &&
						e.st.shift != ddc_pkg::header_byte(e.st.bytes_read[2:0])) begin
						n.st.header_good = 1'b0;
					end
					n.st.bytes_read = e.st.bytes_read + 8'd1;
					n.st.bit_cnt = 4'd0;
					n.st.phase = (n.st.bytes_read < rc) ? PH_RD_LOW : PH_STOP_A;
					n.chain = 1'b1;
				end
			end
			PH_STOP_A: begin
				n.st.scl_out = 1'b0;
				n.st.sda_out = 1'b0;
				n.st.phase = PH_STOP_B;
				n.st.delay = reload;
			end
			PH_STOP_B: begin
				n.st.scl_out = 1'b1;
				n.st.phase = PH_STOP_C;
				n.st.delay = reload;
			end
			PH_STOP_C: begin
				n.st.sda_out = 1'b1;
				n.done = 1'b1;
				if (e.st.pend_status != ddc_pkg::ST_OK) begin
					n.status = e.st.pend_status;
				end else begin
					n.status = (e.st.header_good && rc >= 8'd7) ?
						ddc_pkg::ST_OK : ddc_pkg::ST_BAD_HEADER;
				end
				n.st.phase = PH_IDLE;
				n.st.delay = 16'd0;
			end
			default: begin
				n.st.phase = PH_IDLE;
				n.st.scl_out = 1'b1;
				n.st.sda_out = 1'b1;
			end
		endcase
		return n;
	endfunction

	eng_t e0, e1, e2;

	// a read sample or read ack-wait step runs into the next phase in the same tick
	always_comb begin
		e0 = '0;
		e0.st = st_q;
		e0.status = ddc_pkg::ST_OK;
		e1 = e0;
		e2 = e0;
		if (st_q.delay != 16'd0) begin
			e2.st.delay = st_q.delay - 16'd1;
		end else begin
			e1 = act(e0, go, scl_sense, sda_sense, cfg);
			e2 = e1.chain ? act(e1, go, scl_sense, sda_sense, cfg) : e1;
		end
	end

	assign res_next.scl_release  = e2.st.scl_out;
	assign res_next.sda_release  = e2.st.sda_out;
	assign res_next.byte_valid   = e2.valid;
	assign res_next.byte_value   = e2.value;
	assign res_next.byte_index   = e2.index;
	assign res_next.fetch_done   = e2.done;
	assign res_next.fetch_status = e2.status;
	assign res_next.busy_res     = (e2.st.phase != PH_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q.phase       <= PH_IDLE;
			st_q.bit_cnt     <= 4'd0;
			st_q.shift       <= 8'd0;
			st_q.bytes_read  <= 8'd0;
			st_q.delay       <= 16'd0;
			st_q.header_good <= 1'b1;
			st_q.scl_out     <= 1'b1;
			st_q.sda_out     <= 1'b1;
			st_q.stage       <= STG_ADDR_W;
			st_q.pend_status <= ddc_pkg::ST_OK;
		end else if (advance) begin
			st_q <= e2.st;
		end
	end

endmodule

/* hw/rtl/ddc_edid_fetch_i2c_master_core.sv */
// top level of the ddc edid fetch i2c master: handshakes, config and result register
//
// channel  direction  handshake                 payload
// in       input      in_valid / in_stall       go, scl_sense, sda_sense
// out      output     out_valid / out_stall     scl_release .. busy_res
// cfg      input      cfg_valid / cfg_ready     cfg_index, cfg_data
//
// one tick per transaction, one transaction per cycle while in_stall is low; the bus
// state advances in a single step into the result register; reset does not clear it.
// reset idles the engine with bus drives released, config at defaults, out_valid low.
// in_stall is high only while a result sits in the output register and out is stalled.
// cfg_ready is always high; index 3 is ignored.
`timescale 1ns / 1ps
`include "ddc_edid_fetch_i2c_master_core_assert.svh"

module ddc_edid_fetch_i2c_master_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        go,
	input  logic        scl_sense,
	input  logic        sda_sense,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        scl_release,
	output logic        sda_release,
	output logic        byte_valid,
	output logic [7:0]  byte_value,
	output logic [6:0]  byte_index,
	output logic        fetch_done,
	output logic [2:0]  fetch_status,
	output logic        busy_res,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data
);

	ddc_pkg::cfg_t cfg_q;
	ddc_pkg::res_t res_next;
	ddc_pkg::res_t res_q;
	logic          out_valid_q;
	logic          in_accept;

	assign cfg_ready = 1'b1;
	assign in_stall  = out_valid_q & out_stall;
	assign in_accept = in_valid & ~in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.half_period_ticks <= ddc_pkg::RST_HALF_PERIOD;
			cfg_q.device_address    <= ddc_pkg::RST_DEV_ADDR;
			cfg_q.byte_count        <= ddc_pkg::RST_BYTE_COUNT;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				ddc_pkg::REG_HALF_PERIOD: cfg_q.half_period_ticks <= cfg_data;
				ddc_pkg::REG_DEV_ADDR:    cfg_q.device_address    <= cfg_data[6:0];
				ddc_pkg::REG_BYTE_COUNT:  cfg_q.byte_count        <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	ddc_engine u_engine (
		.clk       (clk),
		.arst_n    (arst_n),
		.advance   (in_accept),
		.go        (go),
		.scl_sense (scl_sense),
		.sda_sense (sda_sense),
		.cfg       (cfg_q),
		.res_next  (res_next)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (in_accept) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept) begin
			res_q <= res_next;
		end
	end

	assign out_valid    = out_valid_q;
	assign scl_release  = res_q.scl_release;
	assign sda_release  = res_q.sda_release;
	assign byte_valid   = res_q.byte_valid;
	assign byte_value   = res_q.byte_value;
	assign byte_index   = res_q.byte_index;
	assign fetch_done   = res_q.fetch_done;
	assign fetch_status = res_q.fetch_status;
	assign busy_res     = res_q.busy_res;

	`DDC_ASSERT_NEXT(a_accept_gives_result, in_valid && !in_stall, out_valid)
	`DDC_ASSERT(a_done_goes_idle, out_valid && fetch_done |-> !busy_res)
	`DDC_ASSERT(a_byte_while_busy, out_valid && byte_valid |-> busy_res && !fetch_done)
	`DDC_ASSERT(a_status_only_on_done, out_valid && !fetch_done |-> fetch_status == ddc_pkg::ST_OK)

endmodule
